@@ rtl/tlik_pkg.sv @@
package tlik_pkg;

	// Field and register widths.
	localparam int IN_W      = 20;
	localparam int LEN_W     = 19;
	localparam int ANG_W     = 17;
	localparam int COS_W     = 16;
	localparam int CFG_IDX_W = 1;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_UPPER = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FORE  = 1'b1;

	// Shared multiplier: signed operands and product.
	localparam int MUL_W  = 21;
	localparam int PROD_W = 2 * MUL_W;

	// Square root unit: radicand and root widths.
	localparam int SQ_IN_W  = 40;
	localparam int SQ_OUT_W = SQ_IN_W / 2;

	// Divider: divisor width and quotient width of the cosine ratio.
	localparam int DIV_W   = 40;
	localparam int DIV_Q_W = 15;

	// CORDIC datapath.
	localparam int CW               = 36;
	localparam int TAB_LEN          = 24;
	localparam int TAB_IDX_W        = 5;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int CORDIC_IN_W      = 21;
	localparam logic signed [CW-1:0] PI_Q30 = 36'sd3373259426;

	// Cosine of one in Q2.14.
	localparam logic signed [COS_W-1:0] COS_ONE = 16'sd16384;

	// Arctangent table, atan(2^-i) * 2^30 as a whole number.
	function automatic logic [30:0] atan_tab(input logic [TAB_IDX_W-1:0] i);
		logic [30:0] v;
		v = '0;
		unique case (i)
			5'd0:  v = 31'd843314857;
			5'd1:  v = 31'd497837829;
			5'd2:  v = 31'd263043836;
			5'd3:  v = 31'd133525158;
			5'd4:  v = 31'd67021686;
			5'd5:  v = 31'd33543515;
			5'd6:  v = 31'd16775850;
			5'd7:  v = 31'd8388437;
			5'd8:  v = 31'd4194282;
			5'd9:  v = 31'd2097149;
			5'd10: v = 31'd1048575;
			5'd11: v = 31'd524287;
			5'd12: v = 31'd262143;
			5'd13: v = 31'd131071;
			5'd14: v = 31'd65535;
			5'd15: v = 31'd32767;
			5'd16: v = 31'd16383;
			5'd17: v = 31'd8191;
			5'd18: v = 31'd4095;
			5'd19: v = 31'd2047;
			5'd20: v = 31'd1023;
			5'd21: v = 31'd511;
			5'd22: v = 31'd255;
			5'd23: v = 31'd127;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/tlik_if.sv @@
// Target channel: one point per transfer.
interface tlik_target_if;
	logic                                valid;
	logic                                ready;
	logic signed [tlik_pkg::IN_W-1:0]    target_x;
	logic signed [tlik_pkg::IN_W-1:0]    target_y;

	modport source (output valid, output target_x, output target_y, input ready);
	modport sink (input valid, input target_x, input target_y, output ready);
endinterface

// Result channel: one joint solution per transfer.
interface tlik_result_if;
	logic                                valid;
	logic                                ready;
	logic                                reachable;
	logic signed [tlik_pkg::ANG_W-1:0]   shoulder_angle;
	logic signed [tlik_pkg::ANG_W-1:0]   elbow_angle;
	logic                                elbow_up;

	modport source (output valid, output reachable, output shoulder_angle,
		output elbow_angle, output elbow_up, input ready);
	modport sink (input valid, input reachable, input shoulder_angle,
		input elbow_angle, input elbow_up, output ready);
endinterface

@@ rtl/tlik_sqrt.sv @@
// Integer square root, one result bit per cycle.
module tlik_sqrt (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [tlik_pkg::SQ_IN_W-1:0]     arg,
	output logic                             done,
	output logic [tlik_pkg::SQ_OUT_W-1:0]    root
);

	logic                            busy_q;
	logic                            done_q;
	logic [tlik_pkg::SQ_IN_W-1:0]    n_q;
	logic [tlik_pkg::SQ_IN_W:0]      r_q;
	logic [tlik_pkg::SQ_IN_W-1:0]    bit_q;
	logic [tlik_pkg::SQ_IN_W:0]      trial;

	assign trial = r_q + {1'b0, bit_q};

	// Control: busy until the last bit position is done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Datapath: classic digit-by-digit root.
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= arg;
			r_q   <= '0;
			bit_q <= tlik_pkg::SQ_IN_W'(1) << (tlik_pkg::SQ_IN_W - 2);
		end else if (busy_q) begin
			if ({1'b0, n_q} >= trial) begin
				n_q <= n_q - trial[tlik_pkg::SQ_IN_W-1:0];
				r_q <= (r_q >> 1) + {1'b0, bit_q};
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[tlik_pkg::SQ_OUT_W-1:0];

endmodule

@@ rtl/tlik_div.sv @@
// Rounded ratio (m * 2^14 + den / 2) / den, restoring, one quotient bit per cycle.
module tlik_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [tlik_pkg::DIV_W-1:0]       m,
	input  logic [tlik_pkg::DIV_W-1:0]       den,
	output logic                             done,
	output logic [tlik_pkg::DIV_Q_W-1:0]     quot
);

	localparam int REM_W = tlik_pkg::DIV_W + tlik_pkg::DIV_Q_W + 1;
	localparam int CNT_W = $clog2(tlik_pkg::DIV_Q_W);

	logic                             busy_q;
	logic                             done_q;
	logic [CNT_W-1:0]                 cnt_q;
	logic [REM_W-1:0]                 rem_q;
	logic [REM_W-1:0]                 dsh_q;
	logic [tlik_pkg::DIV_Q_W-1:0]     quot_q;

	// Control: count down the quotient bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(tlik_pkg::DIV_Q_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: compare against the shifted divisor and subtract.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= (REM_W'(m) << (tlik_pkg::DIV_Q_W - 1)) + REM_W'(den >> 1);
			dsh_q  <= REM_W'(den) << (tlik_pkg::DIV_Q_W - 1);
			quot_q <= '0;
		end else if (busy_q) begin
			if (rem_q >= dsh_q) begin
				rem_q  <= rem_q - dsh_q;
				quot_q <= {quot_q[tlik_pkg::DIV_Q_W-2:0], 1'b1};
			end else begin
				quot_q <= {quot_q[tlik_pkg::DIV_Q_W-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

@@ rtl/tlik_cordic.sv @@
// Vectoring CORDIC atan2, one micro-rotation per cycle, result in Q3.13.
module tlik_cordic #(
	parameter int CORDIC_STEPS = tlik_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	input  logic signed [tlik_pkg::CORDIC_IN_W-1:0] yin,
	input  logic signed [tlik_pkg::CORDIC_IN_W-1:0] xin,
	output logic                                    done,
	output logic signed [tlik_pkg::ANG_W-1:0]       angle
);

	localparam int CW    = tlik_pkg::CW;
	localparam int STEPS = (CORDIC_STEPS < tlik_pkg::TAB_LEN) ? CORDIC_STEPS
		: tlik_pkg::TAB_LEN;

	typedef enum logic [2:0] {
		C_IDLE = 3'b001,
		C_NORM = 3'b010,
		C_ROT  = 3'b100
	} cordic_state_t;

	cordic_state_t                      state_q;
	logic                               done_q;
	logic [tlik_pkg::TAB_IDX_W-1:0]     idx_q;
	logic signed [CW-1:0]               x_q;
	logic signed [CW-1:0]               y_q;
	logic signed [CW-1:0]               z_q;
	logic signed [CW-1:0]               ax;
	logic signed [CW-1:0]               ay;
	logic signed [CW-1:0]               mx;
	logic signed [CW-1:0]               dx;
	logic signed [CW-1:0]               dy;
	logic signed [CW-1:0]               da;
	logic signed [CW-1:0]               zr;
	logic                               last_step;

	// Magnitude of the larger operand steers the normalization.
	always_comb begin
		ax = x_q[CW-1] ? -x_q : x_q;
		ay = y_q[CW-1] ? -y_q : y_q;
		mx = (ax > ay) ? ax : ay;
		dx = y_q >>> idx_q;
		dy = x_q >>> idx_q;
		da = CW'($signed({1'b0, tlik_pkg::atan_tab(idx_q)}));
		zr = z_q + (CW'(1) <<< 16);
		last_step = (idx_q == tlik_pkg::TAB_IDX_W'(STEPS - 1));
	end

	// Sequencer: normalize, mirror, then rotate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q  <= 1'b0;
			idx_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				C_IDLE: begin
					if (start) begin
						state_q <= C_NORM;
						idx_q   <= '0;
					end
				end
				C_NORM: begin
					if (mx == '0) begin
						state_q <= C_IDLE;
						done_q  <= 1'b1;
					end else if (mx >= (CW'(1) <<< 30)) begin
						state_q <= C_ROT;
					end
				end
				C_ROT: begin
					idx_q <= idx_q + 1'b1;
					if (last_step) begin
						state_q <= C_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && start) begin
			x_q <= CW'(xin);
			y_q <= CW'(yin);
			z_q <= '0;
		end else if (state_q == C_NORM) begin
			if (mx == '0) begin
				z_q <= '0;
			end else if (mx < (CW'(1) <<< 22)) begin
				x_q <= x_q <<< 8;
				y_q <= y_q <<< 8;
			end else if (mx < (CW'(1) <<< 30)) begin
				x_q <= x_q <<< 1;
				y_q <= y_q <<< 1;
			end else if (x_q[CW-1]) begin
				// Left half-plane: mirror through the origin and start from +/-pi.
				x_q <= -x_q;
				y_q <= -y_q;
				z_q <= y_q[CW-1] ? -tlik_pkg::PI_Q30 : tlik_pkg::PI_Q30;
			end
		end else if (state_q == C_ROT) begin
			if (!y_q[CW-1]) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + da;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - da;
			end
		end
	end

	assign done  = done_q;
	assign angle = zr[17 + tlik_pkg::ANG_W - 1:17];

endmodule

@@ rtl/two_link_arm_inverse_kinematics.sv @@
// Two-link planar arm inverse kinematics on one shared multiplier, root, divider and CORDIC.
// A rejected target skips the root, CORDIC and divider passes; a reachable one runs the chain
// of root, CORDIC and divider passes one after another (one cosine pass fewer at the origin).
// Throughput: one target at a time; the next is taken once the result has been transferred.
// Reset (arst_n low, asynchronous): link lengths and stored joint angles clear to zero.
module two_link_arm_inverse_kinematics #(
	parameter int CORDIC_STEPS = tlik_pkg::CORDIC_STEPS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [tlik_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tlik_pkg::LEN_W-1:0]         cfg_data,
	tlik_target_if.sink                        target_ch,
	tlik_result_if.source                      result_ch
);

	localparam int MUL_W  = tlik_pkg::MUL_W;
	localparam int PROD_W = tlik_pkg::PROD_W;
	localparam int ANG_W  = tlik_pkg::ANG_W;
	localparam int DIF_W  = ANG_W + 2;

	typedef enum logic [24:0] {
		S_IDLE = 25'd1 << 0,
		S_MXX  = 25'd1 << 1,
		S_MYY  = 25'd1 << 2,
		S_MSUM = 25'd1 << 3,
		S_MDIF = 25'd1 << 4,
		S_ML1  = 25'd1 << 5,
		S_ML2  = 25'd1 << 6,
		S_CHK  = 25'd1 << 7,
		S_SQD  = 25'd1 << 8,
		S_BASE = 25'd1 << 9,
		S_DEN  = 25'd1 << 10,
		S_DENE = 25'd1 << 11,
		S_COS  = 25'd1 << 12,
		S_DIVW = 25'd1 << 13,
		S_CSQ  = 25'd1 << 14,
		S_SARG = 25'd1 << 15,
		S_SQS  = 25'd1 << 16,
		S_ACOS = 25'd1 << 17,
		S_PDIF = 25'd1 << 18,
		S_MP1  = 25'd1 << 19,
		S_MP2  = 25'd1 << 20,
		S_MP3  = 25'd1 << 21,
		S_MP4  = 25'd1 << 22,
		S_PICK = 25'd1 << 23,
		S_OUT  = 25'd1 << 24
	} seq_state_t;

	seq_state_t                            state_q;

	// Configuration and stored angles.
	logic [tlik_pkg::LEN_W-1:0]            l1_q;
	logic [tlik_pkg::LEN_W-1:0]            l2_q;
	logic signed [ANG_W-1:0]               ls_q;
	logic signed [ANG_W-1:0]               le_q;

	// Working registers.
	logic signed [tlik_pkg::IN_W-1:0]      x_q;
	logic signed [tlik_pkg::IN_W-1:0]      y_q;
	logic signed [PROD_W-1:0]              t0_q;
	logic signed [PROD_W-1:0]              t1_q;
	logic signed [PROD_W-1:0]              d2_q;
	logic signed [PROD_W-1:0]              l1sq_q;
	logic signed [PROD_W-1:0]              l2sq_q;
	logic signed [PROD_W-1:0]              n_q;
	logic signed [PROD_W-1:0]              numa_q;
	logic signed [PROD_W-1:0]              nume_q;
	logic signed [PROD_W-1:0]              dena_q;
	logic signed [PROD_W-1:0]              dene_q;
	logic signed [PROD_W-1:0]              dd_q;
	logic [tlik_pkg::SQ_OUT_W-1:0]         dist_q;
	logic signed [tlik_pkg::COS_W-1:0]     c_q;
	logic                                  neg_q;
	logic                                  sel_q;
	logic signed [ANG_W-1:0]               base_q;
	logic signed [ANG_W-1:0]               a_q;
	logic signed [ANG_W-1:0]               e_q;
	logic signed [ANG_W-1:0]               td_q;
	logic signed [ANG_W-1:0]               tu_q;
	logic signed [DIF_W-1:0]               pd_q;
	logic signed [DIF_W-1:0]               qd_q;
	logic signed [DIF_W-1:0]               pu_q;
	logic signed [DIF_W-1:0]               qu_q;

	// Result register.
	logic                                  res_valid_q;
	logic                                  res_reach_q;
	logic                                  res_up_q;
	logic signed [ANG_W-1:0]               res_sh_q;
	logic signed [ANG_W-1:0]               res_el_q;

	// Shared multiplier and helpers.
	logic signed [MUL_W-1:0]               mul_a;
	logic signed [MUL_W-1:0]               mul_b;
	logic signed [PROD_W-1:0]              prod;
	logic signed [MUL_W-1:0]               l1s;
	logic signed [MUL_W-1:0]               l2s;
	logic                                  reject;
	logic signed [PROD_W-1:0]              num_sel;
	logic signed [PROD_W-1:0]              den_sel;
	logic signed [PROD_W-1:0]              num_mag;
	logic signed [PROD_W-1:0]              sarg;
	logic signed [PROD_W-1:0]              du;
	logic signed [ANG_W:0]                 td;
	logic signed [ANG_W:0]                 tu;
	logic in_xfer;
	logic out_xfer;

	// Unit handshakes.
	logic                                  sq_start;
	logic [tlik_pkg::SQ_IN_W-1:0]          sq_arg;
	logic                                  sq_done;
	logic [tlik_pkg::SQ_OUT_W-1:0]         sq_root;
	logic                                  dv_start;
	logic                                  dv_done;
	logic [tlik_pkg::DIV_Q_W-1:0]          dv_quot;
	logic                                  cd_start;
	logic signed [tlik_pkg::CORDIC_IN_W-1:0] cd_y;
	logic signed [tlik_pkg::CORDIC_IN_W-1:0] cd_x;
	logic                                  cd_done;
	logic signed [ANG_W-1:0]               cd_angle;

	assign in_xfer  = target_ch.valid && target_ch.ready;
	assign out_xfer = result_ch.valid && result_ch.ready;

	assign l1s = $signed({2'b00, l1_q});
	assign l2s = $signed({2'b00, l2_q});

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_MXX: begin
				mul_a = MUL_W'(x_q);
				mul_b = MUL_W'(x_q);
			end
			S_MYY: begin
				mul_a = MUL_W'(y_q);
				mul_b = MUL_W'(y_q);
			end
			S_MSUM: begin
				mul_a = l1s + l2s;
				mul_b = l1s + l2s;
			end
			S_MDIF: begin
				mul_a = l1s - l2s;
				mul_b = l1s - l2s;
			end
			S_ML1: begin
				mul_a = l1s;
				mul_b = l1s;
			end
			S_ML2: begin
				mul_a = l2s;
				mul_b = l2s;
			end
			S_DEN: begin
				mul_a = l1s;
				mul_b = $signed({1'b0, dist_q});
			end
			S_DENE: begin
				mul_a = l1s;
				mul_b = l2s;
			end
			S_CSQ: begin
				mul_a = MUL_W'(c_q);
				mul_b = MUL_W'(c_q);
			end
			S_MP1: begin
				mul_a = MUL_W'(pd_q);
				mul_b = MUL_W'(pd_q);
			end
			S_MP2: begin
				mul_a = MUL_W'(qd_q);
				mul_b = MUL_W'(qd_q);
			end
			S_MP3: begin
				mul_a = MUL_W'(pu_q);
				mul_b = MUL_W'(pu_q);
			end
			S_MP4: begin
				mul_a = MUL_W'(qu_q);
				mul_b = MUL_W'(qu_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// Reach test, cosine operand selection and the small sums.
	always_comb begin
		reject  = (d2_q > t0_q) || ((l1_q > l2_q) && (d2_q < t1_q));
		num_sel = sel_q ? nume_q : numa_q;
		den_sel = sel_q ? dene_q : dena_q;
		num_mag = num_sel[PROD_W-1] ? -num_sel : num_sel;
		sarg    = (PROD_W'(1) <<< 28) - t0_q;
		du      = t0_q + t1_q;
		td      = (ANG_W + 1)'(base_q) - (ANG_W + 1)'(a_q);
		tu      = (ANG_W + 1)'(base_q) + (ANG_W + 1)'(a_q);
	end

	// Unit starts.
	assign sq_start = ((state_q == S_CHK) && !reject) || (state_q == S_SARG);
	assign sq_arg   = (state_q == S_SARG) ? sarg[tlik_pkg::SQ_IN_W-1:0]
		: d2_q[tlik_pkg::SQ_IN_W-1:0];
	assign dv_start = (state_q == S_COS) && (den_sel != '0) && (num_sel < den_sel)
		&& (num_sel > -den_sel);
	assign cd_start = sq_done && ((state_q == S_SQD) || (state_q == S_SQS));
	assign cd_y     = (state_q == S_SQD) ? tlik_pkg::CORDIC_IN_W'(y_q)
		: $signed(tlik_pkg::CORDIC_IN_W'(sq_root));
	assign cd_x     = (state_q == S_SQD) ? tlik_pkg::CORDIC_IN_W'(x_q)
		: tlik_pkg::CORDIC_IN_W'(c_q);

	tlik_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.arg    (sq_arg),
		.done   (sq_done),
		.root   (sq_root)
	);

	tlik_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_start),
		.m      (num_mag[tlik_pkg::DIV_W-1:0]),
		.den    (den_sel[tlik_pkg::DIV_W-1:0]),
		.done   (dv_done),
		.quot   (dv_quot)
	);

	tlik_cordic #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cd_start),
		.yin    (cd_y),
		.xin    (cd_x),
		.done   (cd_done),
		.angle  (cd_angle)
	);

	// Sequencer, configuration, stored angles and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			l1_q        <= '0;
			l2_q        <= '0;
			ls_q        <= '0;
			le_q        <= '0;
			res_valid_q <= 1'b0;
			sel_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					tlik_pkg::REG_UPPER: l1_q <= cfg_data;
					tlik_pkg::REG_FORE:  l2_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: if (in_xfer) state_q <= S_MXX;
				S_MXX:  state_q <= S_MYY;
				S_MYY:  state_q <= S_MSUM;
				S_MSUM: state_q <= S_MDIF;
				S_MDIF: state_q <= S_ML1;
				S_ML1:  state_q <= S_ML2;
				S_ML2:  state_q <= S_CHK;
				S_CHK: begin
					if (reject) begin
						state_q     <= S_OUT;
						res_valid_q <= 1'b1;
					end else begin
						state_q <= S_SQD;
					end
				end
				S_SQD:  if (sq_done) state_q <= S_BASE;
				S_BASE: if (cd_done) state_q <= S_DEN;
				S_DEN:  state_q <= S_DENE;
				S_DENE: begin
					state_q <= S_COS;
					sel_q   <= (dist_q == '0);
				end
				S_COS:  state_q <= dv_start ? S_DIVW : S_CSQ;
				S_DIVW: if (dv_done) state_q <= S_CSQ;
				S_CSQ:  state_q <= S_SARG;
				S_SARG: state_q <= S_SQS;
				S_SQS:  if (sq_done) state_q <= S_ACOS;
				S_ACOS: begin
					if (cd_done) begin
						state_q <= sel_q ? S_PDIF : S_COS;
						sel_q   <= 1'b1;
					end
				end
				S_PDIF: state_q <= S_MP1;
				S_MP1:  state_q <= S_MP2;
				S_MP2:  state_q <= S_MP3;
				S_MP3:  state_q <= S_MP4;
				S_MP4:  state_q <= S_PICK;
				S_PICK: begin
					state_q     <= S_OUT;
					res_valid_q <= 1'b1;
					// Ties go to elbow-down.
					if (dd_q <= du) begin
						ls_q <= td_q;
						le_q <= e_q;
					end else begin
						ls_q <= tu_q;
						le_q <= -e_q;
					end
				end
				S_OUT: begin
					if (out_xfer) begin
						state_q     <= S_IDLE;
						res_valid_q <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					x_q <= target_ch.target_x;
					y_q <= target_ch.target_y;
				end
			end
			S_MXX:  t0_q <= prod;
			S_MYY:  t1_q <= prod;
			S_MSUM: begin
				d2_q <= t0_q + t1_q;
				t0_q <= prod;
			end
			S_MDIF: t1_q <= prod;
			S_ML1:  l1sq_q <= prod;
			S_ML2:  l2sq_q <= prod;
			S_CHK: begin
				n_q <= d2_q - l2sq_q;
				if (reject) begin
					res_reach_q <= 1'b0;
					res_up_q    <= 1'b0;
					res_sh_q    <= ls_q;
					res_el_q    <= le_q;
				end
			end
			S_SQD:  if (sq_done) dist_q <= sq_root;
			S_BASE: if (cd_done) base_q <= cd_angle;
			S_DEN: begin
				dena_q <= prod <<< 1;
				numa_q <= n_q + l1sq_q;
				nume_q <= n_q - l1sq_q;
			end
			S_DENE: begin
				dene_q <= prod <<< 1;
				if (dist_q == '0) a_q <= '0;
			end
			S_COS: begin
				// Degenerate and saturated ratios clamp to plus or minus one.
				neg_q <= num_sel[PROD_W-1];
				if (den_sel == '0) begin
					c_q <= num_sel[PROD_W-1] ? -tlik_pkg::COS_ONE : tlik_pkg::COS_ONE;
				end else if (num_sel >= den_sel) begin
					c_q <= tlik_pkg::COS_ONE;
				end else if (num_sel <= -den_sel) begin
					c_q <= -tlik_pkg::COS_ONE;
				end
			end
			S_DIVW: begin
				if (dv_done) begin
					c_q <= neg_q ? -$signed({1'b0, dv_quot}) : $signed({1'b0, dv_quot});
				end
			end
			S_CSQ: t0_q <= prod;
			S_ACOS: begin
				if (cd_done) begin
					if (sel_q) e_q <= cd_angle;
					else a_q <= cd_angle;
				end
			end
			S_PDIF: begin
				td_q <= td[ANG_W-1:0];
				tu_q <= tu[ANG_W-1:0];
				pd_q <= DIF_W'(td) - DIF_W'(ls_q);
				pu_q <= DIF_W'(tu) - DIF_W'(ls_q);
				qd_q <= DIF_W'(e_q) - DIF_W'(le_q);
				qu_q <= -DIF_W'(e_q) - DIF_W'(le_q);
			end
			S_MP1:  t0_q <= prod;
			S_MP2:  t1_q <= prod;
			S_MP3: begin
				dd_q <= t0_q + t1_q;
				t0_q <= prod;
			end
			S_MP4:  t1_q <= prod;
			S_PICK: begin
				res_reach_q <= 1'b1;
				if (dd_q <= du) begin
					res_up_q <= 1'b0;
					res_sh_q <= td_q;
					res_el_q <= e_q;
				end else begin
					res_up_q <= 1'b1;
					res_sh_q <= tu_q;
					res_el_q <= -e_q;
				end
			end
			default: ;
		endcase
	end

	// Channel ports.
	assign target_ch.ready          = (state_q == S_IDLE);
	assign result_ch.valid          = res_valid_q;
	assign result_ch.reachable      = res_reach_q;
	assign result_ch.shoulder_angle = res_sh_q;
	assign result_ch.elbow_angle    = res_el_q;
	assign result_ch.elbow_up       = res_up_q;

endmodule
